>>> design/ksdr_pkg.sv
// Package: shared types and constants for the subset DP ranker.
`timescale 1ns / 1ps
package ksdr_pkg;
  localparam int SCORE_BITS = 23;
  localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUBSET,
    ST_TERM,
    ST_SCAN,
    ST_WRITE,
    ST_READ,
    ST_WALK,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic init_empty;
    logic subset_begin;
    logic term_step;
    logic subset_write;
    logic walk_begin;
    logic walk_read;
    logic walk_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last_subset;
    logic term_last;
    logic walk_done;
    logic emit_last;
  } dp_status_t;
endpackage

>>> design/ksdr_ram.sv
// Generic single-port-write, single-read RAM with registered read.
`timescale 1ns / 1ps
module ksdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/ksdr_datapath.sv
// Datapath: weight matrix, subset tables, cost accumulation and ranking walk.
`timescale 1ns / 1ps
module ksdr_datapath #(
  parameter int MAX_CANDS   = 12,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load_we,
  input  logic [3:0]                    front_cand,
  input  logic [3:0]                    behind_cand,
  input  logic [WEIGHT_BITS-1:0]        pair_weight,
  input  logic [3:0]                    cands_in_use,
  input  ksdr_pkg::dp_cmd_t             cmd,
  output ksdr_pkg::dp_status_t          status,
  output logic [3:0]                    rank_position,
  output logic [3:0]                    ranked_cand,
  output logic [ksdr_pkg::SCORE_BITS-1:0] total_score,
  output logic                          last_of_run,
  output logic                          result_valid
);
  import ksdr_pkg::*;

  localparam int CB = $clog2(MAX_CANDS);
  localparam int NB = $clog2(MAX_CANDS + 1);
  localparam int WD = MAX_CANDS * MAX_CANDS;
  localparam int WA = $clog2(WD);
  localparam int SUBSETS = 1 << MAX_CANDS;
  localparam int PB = ((WEIGHT_BITS > SCORE_BITS) ? WEIGHT_BITS : SCORE_BITS) + 1;

  // weight matrix in RAM, valid bit per entry so unloaded pairs read zero
  logic [WD-1:0]          wvalid;
  logic                   load_ok;
  logic [WA-1:0]          w_waddr;
  logic [WEIGHT_BITS-1:0] w_rdata;

  logic [NB-1:0]        n_act;
  logic [MAX_CANDS-1:0] full_set;
  logic [MAX_CANDS-1:0] s_cur;
  logic [CB-1:0]        d_idx;
  logic [CB-1:0]        c_idx;
  logic [MAX_CANDS-1:0] rest;
  logic [SCORE_BITS-1:0] push;
  logic [SCORE_BITS-1:0] best;
  logic [CB-1:0]        pick;
  logic                 have;
  logic [NB-1:0]        pos;
  logic [SCORE_BITS-1:0] score;
  logic [CB-1:0]        order [MAX_CANDS];

  logic [SCORE_BITS-1:0] cost_rdata;
  logic [3:0]            choice_rdata;
  logic [MAX_CANDS-1:0]  cost_raddr;
  logic [MAX_CANDS-1:0]  cost_waddr;
  logic                  cost_we;
  logic [SCORE_BITS-1:0] cost_wdata;
  logic [3:0]            choice_wdata;
  logic [CB-1:0]         walk_pick;

  logic [WA-1:0]         w_idx;
  logic                  d_in;
  logic                  c_in;

  // second stage of the term pipeline
  logic                  p_val;
  logic                  p_term;
  logic                  p_din;
  logic                  p_clast;
  logic                  p_wv;
  logic [CB-1:0]         p_d;

  logic [PB-1:0]         term_w;
  logic [PB-1:0]         push_sum;
  logic [SCORE_BITS-1:0] push_sat;
  logic [SCORE_BITS:0]   cand_cost;
  logic [SCORE_BITS-1:0] cand_sat;

  always_comb begin
    if (cands_in_use == 4'd0) begin
      n_act = NB'(1);
    end else if (32'(cands_in_use) > MAX_CANDS) begin
      n_act = NB'(MAX_CANDS);
    end else begin
      n_act = NB'(cands_in_use);
    end
  end

  assign full_set = MAX_CANDS'((MAX_CANDS + 1)'(1) << n_act) - MAX_CANDS'(1);

  assign load_ok = load_we && 32'(front_cand) < MAX_CANDS && 32'(behind_cand) < MAX_CANDS;
  assign w_waddr = WA'(32'(front_cand) * MAX_CANDS + 32'(behind_cand));

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
    end else if (load_ok) begin
      wvalid[w_waddr] <= 1'b1;
    end
  end

  ksdr_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(WD)) u_weight (
    .clk(clk), .we(load_ok), .waddr(w_waddr), .wdata(pair_weight),
    .raddr(w_idx), .rdata(w_rdata)
  );

  assign w_idx = WA'(32'(d_idx) * MAX_CANDS + 32'(c_idx));
  assign d_in  = s_cur[d_idx];
  assign c_in  = rest[c_idx];
  assign rest  = s_cur & ~(MAX_CANDS'(1) << d_idx);

  // cost read address: rest during terms, s_cur during walk
  assign cost_raddr = cmd.walk_read ? s_cur : rest;
  assign walk_pick  = choice_rdata[CB-1:0];

  assign status.last_subset = (s_cur == full_set);
  assign status.term_last   = (32'(c_idx) == 32'(n_act) - 1) && (32'(d_idx) == 32'(n_act) - 1);
  assign status.walk_done   = (32'(pos) == 32'(n_act) - 1);
  assign status.emit_last   = (pos == '0);

  always_comb begin
    cost_we      = 1'b0;
    cost_waddr   = s_cur;
    cost_wdata   = best;
    choice_wdata = 4'(pick);
    if (cmd.init_empty) begin
      cost_we      = 1'b1;
      cost_waddr   = '0;
      cost_wdata   = '0;
      choice_wdata = '0;
    end else if (cmd.subset_write) begin
      cost_we = 1'b1;
    end
  end

  ksdr_ram #(.WIDTH(SCORE_BITS), .DEPTH(SUBSETS)) u_cost (
    .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
    .raddr(cost_raddr), .rdata(cost_rdata)
  );
  ksdr_ram #(.WIDTH(4), .DEPTH(SUBSETS)) u_choice (
    .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(choice_wdata),
    .raddr(cost_raddr), .rdata(choice_rdata)
  );

  // stage 1 issues weight and rest-cost reads for (d,c); stage 2 sums them
  always_ff @(posedge clk) begin
    if (rst) begin
      p_val <= 1'b0;
    end else begin
      p_val <= cmd.term_step;
    end
  end

  always_ff @(posedge clk) begin
    p_term  <= d_in && c_in;
    p_din   <= d_in;
    p_clast <= (32'(c_idx) == 32'(n_act) - 1);
    p_wv    <= wvalid[w_idx];
    p_d     <= d_idx;
  end

  assign term_w    = (p_term && p_wv) ? PB'(w_rdata) : '0;
  assign push_sum  = PB'(push) + term_w;
  assign push_sat  = push_sum > PB'(SCORE_MAX) ? SCORE_MAX : push_sum[SCORE_BITS-1:0];
  assign cand_cost = (SCORE_BITS + 1)'(cost_rdata) + (SCORE_BITS + 1)'(push_sat);
  assign cand_sat  = cand_cost > (SCORE_BITS + 1)'(SCORE_MAX) ? SCORE_MAX
                                                              : cand_cost[SCORE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.subset_begin) begin
      push <= '0;
      have <= 1'b0;
    end else if (p_val) begin
      if (p_clast) begin
        push <= '0;
        if (p_din && (!have || cand_sat < best)) begin
          best <= cand_sat;
          pick <= p_d;
          have <= 1'b1;
        end
      end else begin
        push <= push_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_empty) begin
      s_cur <= MAX_CANDS'(1);
      d_idx <= '0;
      c_idx <= '0;
    end else if (cmd.subset_begin) begin
      d_idx <= '0;
      c_idx <= '0;
    end else if (cmd.term_step) begin
      if (32'(c_idx) == 32'(n_act) - 1) begin
        c_idx <= '0;
        d_idx <= d_idx + CB'(1);
      end else begin
        c_idx <= c_idx + CB'(1);
      end
    end else if (cmd.walk_begin) begin
      s_cur <= full_set;
      pos   <= '0;
    end else if (cmd.subset_write) begin
      s_cur <= s_cur + MAX_CANDS'(1);
    end else if (cmd.walk_step) begin
      order[pos[CB-1:0]] <= walk_pick;
      s_cur <= s_cur & ~(MAX_CANDS'(1) << walk_pick);
      if (pos == '0) begin
        score <= cost_rdata;
      end
      if (!status.walk_done) begin
        pos <= pos + NB'(1);
      end
    end else if (cmd.emit) begin
      pos <= pos - NB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rank_position <= 4'(pos);
      ranked_cand   <= 4'(order[pos[CB-1:0]]);
      total_score   <= score;
      last_of_run   <= (pos == '0);
    end
  end
endmodule

>>> design/ksdr_ctrl.sv
// Controller: sequences the subset DP, the back-pointer walk and emission.
`timescale 1ns / 1ps
module ksdr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 solve_req,
  input  ksdr_pkg::dp_status_t status,
  output ksdr_pkg::dp_cmd_t    cmd,
  output logic                 busy
);
  import ksdr_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (solve_req) state_next = ST_SUBSET;
      ST_SUBSET: state_next = ST_TERM;
      ST_TERM:   if (status.term_last) state_next = ST_SCAN;
      ST_SCAN:   state_next = ST_WRITE;
      ST_WRITE:  state_next = status.last_subset ? ST_READ : ST_SUBSET;
      ST_READ:   state_next = ST_WALK;
      ST_WALK:   state_next = status.walk_done ? ST_EMIT : ST_READ;
      ST_EMIT:   if (status.emit_last) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:   cmd.init_empty = solve_req;
      ST_SUBSET: cmd.subset_begin = 1'b1;
      ST_TERM:   cmd.term_step = 1'b1;
      ST_SCAN:   cmd = '0;
      ST_WRITE: begin
        cmd.subset_write = 1'b1;
        cmd.walk_begin   = status.last_subset;
      end
      ST_READ:   cmd.walk_read = 1'b1;
      ST_WALK:   cmd.walk_step = 1'b1;
      ST_EMIT:   cmd.emit = 1'b1;
      default:   cmd = '0;
    endcase
  end

  assign busy = (state != ST_IDLE);
endmodule

>>> design/kemeny_subset_dp_ranker.sv
// Top level: Kemeny consensus ranker by subset dynamic programming.
// Usage:
//   start with command=0 loads one pair weight (front before behind); taken
//   every cycle while busy is low, no result.
//   start with command=1 solves over the first n = cands_in_use candidates
//   and emits one result per candidate, last position first, strobed by
//   result_valid for one cycle each; last_of_run marks position 0.
//   A solve keeps busy high through all 2^n - 1 nonempty subsets: each
//   has a setup state, a term step per candidate pair (one matrix read
//   each), a pipeline drain and a table write; the back-pointer walk has a
//   read state and a step state per position for the registered RAM read;
//   then the emit states. The n results come on consecutive cycles, the
//   last one as busy falls, when a new request may already be taken.
//   cfg_valid/cfg_ready write cands_in_use; cfg_ready is low while busy.
//   Reset clears the weight matrix valid bits (all weights read as zero)
//   and sets cands_in_use to 12. The subset RAMs need no clearing.
//   The receiver cannot stall: each result is shown once.
`timescale 1ns / 1ps
module kemeny_subset_dp_ranker #(
  parameter int MAX_CANDS   = 12,
  parameter int WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [3:0]  front_cand,
  input  logic [3:0]  behind_cand,
  input  logic [15:0] pair_weight,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output logic        result_valid,
  output logic [3:0]  rank_position,
  output logic [3:0]  ranked_cand,
  output logic [22:0] total_score,
  output logic        last_of_run
);
  import ksdr_pkg::*;

  logic [3:0]  cands_in_use;
  dp_cmd_t     cmd;
  dp_status_t  status;
  logic        accept;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cands_in_use <= 4'd12;
    end else if (cfg_valid && cfg_ready) begin
      cands_in_use <= cfg_data;
    end
  end

  ksdr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .solve_req(accept && command == CMD_SOLVE),
    .status(status), .cmd(cmd), .busy(busy)
  );

  ksdr_datapath #(.MAX_CANDS(MAX_CANDS), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .load_we(accept && command == CMD_LOAD),
    .front_cand(front_cand), .behind_cand(behind_cand),
    .pair_weight(WEIGHT_BITS'(pair_weight)),
    .cands_in_use(cands_in_use), .cmd(cmd), .status(status),
    .rank_position(rank_position), .ranked_cand(ranked_cand),
    .total_score(total_score), .last_of_run(last_of_run),
    .result_valid(result_valid)
  );

  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_run |-> busy)
    else $error("result strobe after run ended");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_run |-> !busy)
    else $error("busy after final result");
  a_pos_desc: assert property (@(posedge clk) disable iff (rst)
    result_valid && $past(result_valid) |-> rank_position == $past(rank_position) - 4'd1)
    else $error("rank position not descending");
endmodule
